>>> hdl/fhr_pkg.sv
// ----------------------------------------------------------------------------
// fhr_pkg
// Shared types and constants for the framed Hamming(7,4) receiver.
// ----------------------------------------------------------------------------
package fhr_pkg;

    localparam int WORD_W        = 32;
    localparam int MESSAGE_BYTES = 8;
    localparam int BYTE_W        = 8;
    localparam int NIBBLE_W      = 4;
    localparam int FRAME_W       = MESSAGE_BYTES * BYTE_W;

    localparam logic [WORD_W-1:0] HEADER_RESET = 32'hFFFF_FFFF;

    // frame position
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    // status from frame control to the result stage
    typedef struct packed {
        logic emit;     // held word completes a frame
        logic advance;  // held word leaves the input register this cycle
    } frame_stat_t;

    // syndrome values that point at a data bit
    localparam logic [2:0] SYN_D3 = 3'd3;
    localparam logic [2:0] SYN_D5 = 3'd5;
    localparam logic [2:0] SYN_D6 = 3'd6;
    localparam logic [2:0] SYN_D7 = 3'd7;

endpackage

>>> hdl/fhr_hamming_dec.sv
// ----------------------------------------------------------------------------
// fhr_hamming_dec
// Hamming(7,4) single-error-correcting decode of one byte; bit 7 ignored.
// ----------------------------------------------------------------------------
module fhr_hamming_dec
    import fhr_pkg::*;
(
    input  logic [BYTE_W-1:0]   code_byte,
    output logic [NIBBLE_W-1:0] data_nibble
);

    logic [2:0] syn;

    // code position p sits in bit 7-p
    assign syn[0] = code_byte[6] ^ code_byte[4] ^ code_byte[2] ^ code_byte[0];
    assign syn[1] = code_byte[5] ^ code_byte[4] ^ code_byte[1] ^ code_byte[0];
    assign syn[2] = code_byte[3] ^ code_byte[2] ^ code_byte[1] ^ code_byte[0];

    // only data positions matter; parity flips leave the data as is
    always_comb begin
        data_nibble = {code_byte[4], code_byte[2], code_byte[1], code_byte[0]};
        unique case (syn)
            SYN_D3:  data_nibble[3] = ~code_byte[4];
            SYN_D5:  data_nibble[2] = ~code_byte[2];
            SYN_D6:  data_nibble[1] = ~code_byte[1];
            SYN_D7:  data_nibble[0] = ~code_byte[0];
            default: data_nibble = {code_byte[4], code_byte[2], code_byte[1], code_byte[0]};
        endcase
    end

endmodule

>>> hdl/fhr_frame_ctrl.sv
// ----------------------------------------------------------------------------
// fhr_frame_ctrl
// Input register, header register and frame phase tracking.
// ----------------------------------------------------------------------------
module fhr_frame_ctrl
    import fhr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_received_word,
    input  logic              cfg_valid,
    input  logic [WORD_W-1:0] cfg_data,
    input  logic              out_free,
    output frame_stat_t       stat,
    output logic [FRAME_W-1:0] frame_words
);

    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic [WORD_W-1:0] header_reg;
    logic [WORD_W-1:0] first_half_reg;
    phase_t            phase_reg, phase_next;

    // held word moves on unless it finishes a frame and the result is blocked
    assign stat.emit    = in_valid_reg && (phase_reg == PH_SECOND);
    assign stat.advance = in_valid_reg && (!stat.emit || out_free);
    assign s_ready      = !in_valid_reg || stat.advance;

    assign frame_words = {first_half_reg, in_word_reg};

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_word_reg <= s_received_word;
        end
    end

    // header register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
        end else if (cfg_valid) begin
            header_reg <= cfg_data;
        end
    end

    // first data word
    always_ff @(posedge aclk) begin
        if (stat.advance && (phase_reg == PH_FIRST)) begin
            first_half_reg <= in_word_reg;
        end
    end

    // phase register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // phase next state
    always_comb begin
        phase_next = phase_reg;
        if (stat.advance) begin
            unique case (phase_reg)
                PH_FIRST:  phase_next = PH_SECOND;
                PH_SECOND: phase_next = PH_IDLE;
                default:   phase_next = (in_word_reg == header_reg) ? PH_FIRST : PH_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/framed_hamming74_receiver_core.sv
// ----------------------------------------------------------------------------
// framed_hamming74_receiver_core
// Framed Hamming(7,4) receiver: header, two data words, one decoded word.
// ----------------------------------------------------------------------------
// Path: a second data word is captured in the input register, then decoded
// into the result register once that register is free or being taken.
// Throughput: one word per cycle; the input stalls only while a word that ends
// a frame waits on a full result register that is not being taken.
// Reset: header register to all ones, frame phase to idle, both stages empty.
// ----------------------------------------------------------------------------
module framed_hamming74_receiver_core
    import fhr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [WORD_W-1:0] s_received_word,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [WORD_W-1:0] m_decoded_message,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WORD_W-1:0] cfg_data
);

    frame_stat_t                            stat;
    logic [FRAME_W-1:0]                     frame_words;
    logic [MESSAGE_BYTES*NIBBLE_W-1:0]      msg_next;
    logic                                   m_valid_reg;
    logic [WORD_W-1:0]                      msg_reg;
    logic                                   out_free;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    fhr_frame_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_received_word (s_received_word),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .out_free        (out_free),
        .stat            (stat),
        .frame_words     (frame_words)
    );

    // byte i is taken most significant first; nibble i lands in bits 4i+3..4i
    for (genvar i = 0; i < MESSAGE_BYTES; i++) begin : g_dec
        fhr_hamming_dec u_dec (
            .code_byte   (frame_words[FRAME_W-1-BYTE_W*i -: BYTE_W]),
            .data_nibble (msg_next[NIBBLE_W*i +: NIBBLE_W])
        );
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= stat.emit;
        end
        if (out_free && stat.emit) begin
            msg_reg <= msg_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_decoded_message = msg_reg;

endmodule
